// ----- rtl/core/pcs_pkg.sv -----
package pcs_pkg;

   localparam int TableEntries = 64;
   localparam int SecW   = 32;
   localparam int UsecW  = 20;
   localparam int LenW   = 18;
   localparam int MacW   = 48;
   localparam int CntW   = 32;
   localparam int BytesW = 48;

   localparam logic [CntW-1:0]   CntMax   = {CntW{1'b1}};
   localparam logic [BytesW-1:0] BytesMax = {BytesW{1'b1}};
   localparam logic [LenW-1:0]   LenMax   = {LenW{1'b1}};

   // controller to datapath
   typedef struct packed {
      logic load;      // capture a new transaction, start search
      logic step;      // compare one table entry
      logic commit;    // write tables and scalar statistics
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic search_done;
   } status_type;

endpackage

// ----- rtl/core/packet_capture_statistics_top.sv -----
// Flow: an accepted transaction is loaded, both address tables are searched, the results
// are committed and then held in the output state; the search covers at most the larger
// fill of the two tables, and a hit ends the scan early.
// Throughput: one item at a time, the next transaction accepted the cycle after the result
// is taken; both tables are scanned side by side, one entry per cycle through a registered
// memory read, so the table scan sets the rate.
// Reset: synchronous, active high; clears statistics and table fill counts, no sweep.
module packet_capture_statistics_top #(
   parameter int TableEntries = pcs_pkg::TableEntries
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // stamp_seconds[31:0], stamp_micros[51:32], wire_length[69:52],
   // captured_length[87:70], source_mac[135:88], dest_mac[183:136]
   input  logic [183:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // packets_seen[31:0], min_length[49:32], max_length[67:50],
   // captured_bytes[115:68], start_seconds[147:116], start_micros[167:148],
   // end_seconds[199:168], end_micros[219:200], sender_count[251:220],
   // receiver_count[283:252], sender_dropped[284], receiver_dropped[285]
   output logic [287:0] rsp_tdata
);

   pcs_pkg::cmd_type    cmd;
   pcs_pkg::status_type status;

   assign rsp_tdata[287:286] = 2'b00;

   pcs_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .status, .cmd
   );

   // result registers stay stable in the output state until taken
   pcs_datapath #(.TableEntries(TableEntries)) u_dp (
      .clock, .reset, .cmd, .status,
      .stamp_seconds   (req_tdata[31:0]),
      .stamp_micros    (req_tdata[51:32]),
      .wire_length     (req_tdata[69:52]),
      .captured_length (req_tdata[87:70]),
      .source_mac      (req_tdata[135:88]),
      .dest_mac        (req_tdata[183:136]),
      .packets_seen    (rsp_tdata[31:0]),
      .min_length      (rsp_tdata[49:32]),
      .max_length      (rsp_tdata[67:50]),
      .captured_bytes  (rsp_tdata[115:68]),
      .start_seconds   (rsp_tdata[147:116]),
      .start_micros    (rsp_tdata[167:148]),
      .end_seconds     (rsp_tdata[199:168]),
      .end_micros      (rsp_tdata[219:200]),
      .sender_count    (rsp_tdata[251:220]),
      .receiver_count  (rsp_tdata[283:252]),
      .sender_dropped  (rsp_tdata[284]),
      .receiver_dropped(rsp_tdata[285])
   );

   // never accept while a result is pending
   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid))
      else $error("ready while result pending");

   // a dropped address reports a zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[284] |-> rsp_tdata[251:220] == '0)
      else $error("sender drop with nonzero count");

   // commit happens only after both searches finish
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(status.search_done))
      else $error("commit before search done");

endmodule

// ----- rtl/core/pcs_ctrl.sv -----
module pcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pcs_pkg::status_type  status,
   output pcs_pkg::cmd_type     cmd
);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StSearch = 2'd1;
   localparam logic [1:0] StCommit = 2'd2;
   localparam logic [1:0] StOut    = 2'd3;

   logic [1:0] state_ff, state_in;

   // a new item may enter once the last result has gone out
   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = (state_ff == StOut);

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = StSearch;
            end
         end
         StSearch: begin
            if (status.search_done) state_in = StCommit;
            else                    cmd.step = 1'b1;
         end
         StCommit: begin
            cmd.commit = 1'b1;
            state_in   = StOut;
         end
         StOut: begin
            if (rsp_tready) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= StIdle;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/core/pcs_table.sv -----
module pcs_table #(
   parameter int Entries = pcs_pkg::TableEntries
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic                       step,
   input  logic                       commit,
   input  logic [pcs_pkg::MacW-1:0]   key,
   output logic                       done,
   output logic [pcs_pkg::CntW-1:0]   count,
   output logic                       dropped
);

   localparam int IdxW  = (Entries > 1) ? $clog2(Entries) : 1;
   localparam int FillW = $clog2(Entries + 1);
   localparam logic [FillW-1:0] FillFull = FillW'(Entries);

   logic [pcs_pkg::MacW-1:0] keys_mem [Entries];
   logic [pcs_pkg::CntW-1:0] cnts_mem [Entries];

   logic [FillW-1:0] fill_ff, ptr_ff;
   logic             hit_ff;
   logic [IdxW-1:0]  hit_idx_ff;
   logic [pcs_pkg::CntW-1:0] hit_cnt_ff;
   logic [pcs_pkg::MacW-1:0] key_rd_ff;
   logic [pcs_pkg::CntW-1:0] cnt_rd_ff;
   logic             rd_valid_ff;
   logic [IdxW-1:0]  rd_idx_ff;
   logic [pcs_pkg::CntW-1:0] new_cnt;
   logic [IdxW-1:0]  wr_idx;

   // search is over when every filled entry was compared or a hit was seen
   assign done = hit_ff || (!rd_valid_ff && ptr_ff >= fill_ff);

   // registered reads: one entry per cycle, compared the cycle after
   always_ff @(posedge clock) begin
      key_rd_ff <= keys_mem[ptr_ff[IdxW-1:0]];
      cnt_rd_ff <= cnts_mem[ptr_ff[IdxW-1:0]];
      rd_idx_ff <= ptr_ff[IdxW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         hit_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else if (load) begin
         ptr_ff      <= '0;
         hit_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else if (step && !hit_ff) begin
         if (rd_valid_ff && key_rd_ff == key) begin
            hit_ff      <= 1'b1;
            rd_valid_ff <= 1'b0;
         end else if (ptr_ff < fill_ff) begin
            rd_valid_ff <= 1'b1;
            ptr_ff      <= ptr_ff + 1'b1;
         end else begin
            rd_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && !hit_ff && rd_valid_ff && key_rd_ff == key) begin
         hit_idx_ff <= rd_idx_ff;
         hit_cnt_ff <= cnt_rd_ff;
      end
   end

   assign new_cnt = hit_ff ? ((hit_cnt_ff == pcs_pkg::CntMax) ? hit_cnt_ff
                                                              : hit_cnt_ff + 1'b1)
                           : pcs_pkg::CntW'(1);
   assign wr_idx  = hit_ff ? hit_idx_ff : fill_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (commit && (hit_ff || fill_ff != FillFull)) begin
         cnts_mem[wr_idx] <= new_cnt;
         if (!hit_ff) keys_mem[wr_idx] <= key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else if (commit && !hit_ff && fill_ff != FillFull) fill_ff <= fill_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         dropped <= !hit_ff && fill_ff == FillFull;
         count   <= (!hit_ff && fill_ff == FillFull) ? '0 : new_cnt;
      end
   end

endmodule

// ----- rtl/core/pcs_datapath.sv -----
module pcs_datapath #(
   parameter int TableEntries = pcs_pkg::TableEntries
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pcs_pkg::cmd_type            cmd,
   output pcs_pkg::status_type         status,
   input  logic [pcs_pkg::SecW-1:0]    stamp_seconds,
   input  logic [pcs_pkg::UsecW-1:0]   stamp_micros,
   input  logic [pcs_pkg::LenW-1:0]    wire_length,
   input  logic [pcs_pkg::LenW-1:0]    captured_length,
   input  logic [pcs_pkg::MacW-1:0]    source_mac,
   input  logic [pcs_pkg::MacW-1:0]    dest_mac,
   output logic [pcs_pkg::CntW-1:0]    packets_seen,
   output logic [pcs_pkg::LenW-1:0]    min_length,
   output logic [pcs_pkg::LenW-1:0]    max_length,
   output logic [pcs_pkg::BytesW-1:0]  captured_bytes,
   output logic [pcs_pkg::SecW-1:0]    start_seconds,
   output logic [pcs_pkg::UsecW-1:0]   start_micros,
   output logic [pcs_pkg::SecW-1:0]    end_seconds,
   output logic [pcs_pkg::UsecW-1:0]   end_micros,
   output logic [pcs_pkg::CntW-1:0]    sender_count,
   output logic [pcs_pkg::CntW-1:0]    receiver_count,
   output logic                        sender_dropped,
   output logic                        receiver_dropped
);

   localparam int StampW = pcs_pkg::SecW + pcs_pkg::UsecW;

   logic [StampW-1:0]           stamp_ff, first_ff, last_ff;
   logic [pcs_pkg::LenW-1:0]    wlen_ff, clen_ff, min_ff, max_ff;
   logic [pcs_pkg::MacW-1:0]    smac_ff, dmac_ff;
   logic [pcs_pkg::CntW-1:0]    total_ff;
   logic [pcs_pkg::BytesW:0]    sum;
   logic [pcs_pkg::BytesW-1:0]  bytes_ff;
   logic                        s_done, r_done;

   // hold the item for the whole search
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         stamp_ff <= {stamp_seconds, stamp_micros};
         wlen_ff  <= wire_length;
         clen_ff  <= captured_length;
         smac_ff  <= source_mac;
         dmac_ff  <= dest_mac;
      end
   end

   assign sum = {1'b0, bytes_ff} + (pcs_pkg::BytesW+1)'(clen_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         last_ff  <= '0;
         total_ff <= '0;
         min_ff   <= pcs_pkg::LenMax;
         max_ff   <= '0;
         bytes_ff <= '0;
      end else if (cmd.commit) begin
         if (first_ff == '0 || stamp_ff < first_ff) first_ff <= stamp_ff;
         if (last_ff == '0 || stamp_ff > last_ff)   last_ff  <= stamp_ff;
         if (total_ff != pcs_pkg::CntMax) total_ff <= total_ff + 1'b1;
         if (wlen_ff < min_ff) min_ff <= wlen_ff;
         if (wlen_ff > max_ff) max_ff <= wlen_ff;
         bytes_ff <= sum[pcs_pkg::BytesW] ? pcs_pkg::BytesMax
                                          : sum[pcs_pkg::BytesW-1:0];
      end
   end

   pcs_table #(.Entries(TableEntries)) u_sender (
      .clock, .reset, .load(cmd.load), .step(cmd.step), .commit(cmd.commit),
      .key(smac_ff), .done(s_done), .count(sender_count), .dropped(sender_dropped)
   );

   pcs_table #(.Entries(TableEntries)) u_receiver (
      .clock, .reset, .load(cmd.load), .step(cmd.step), .commit(cmd.commit),
      .key(dmac_ff), .done(r_done), .count(receiver_count),
      .dropped(receiver_dropped)
   );

   assign status.search_done = s_done && r_done;

   assign packets_seen   = total_ff;
   assign min_length     = min_ff;
   assign max_length     = max_ff;
   assign captured_bytes = bytes_ff;
   assign start_seconds  = first_ff[StampW-1:pcs_pkg::UsecW];
   assign start_micros   = first_ff[pcs_pkg::UsecW-1:0];
   assign end_seconds    = last_ff[StampW-1:pcs_pkg::UsecW];
   assign end_micros     = last_ff[pcs_pkg::UsecW-1:0];

endmodule
